// ===== hw/rtl/hcv_pkg.sv =====
// hcv_pkg: shared constants, codes and stage record types for the hex cell index validator
// no dependencies; imported by every module of the block

package hcv_pkg;

   // index layout
   localparam int INDEX_W    = 64;
   localparam int TOP_POS    = 63;
   localparam int MODE_LSB   = 59;
   localparam int MODE_W     = 4;
   localparam int AUX_POS    = 56;
   localparam int AUX_W      = 3;
   localparam int RES_POS    = 52;
   localparam int RES_W      = 4;
   localparam int BASE_POS   = 45;
   localparam int BASE_W     = 7;
   localparam int DIGIT_W    = 3;
   localparam int MAX_DIGITS = 15;

   localparam logic [DIGIT_W-1:0] DIGIT_SEVEN = 3'b111;
   localparam logic [DIGIT_W-1:0] DIGIT_ONE   = 3'd1;

   // modes
   localparam logic [MODE_W-1:0] MODE_CELL   = 4'd1;
   localparam logic [MODE_W-1:0] MODE_EDGE   = 4'd2;
   localparam logic [MODE_W-1:0] MODE_VERTEX = 4'd5;

   // auxiliary field ranges
   localparam logic [AUX_W-1:0] EDGE_DIR_MIN = 3'd1;
   localparam logic [AUX_W-1:0] EDGE_DIR_MAX = 3'd6;
   localparam logic [AUX_W-1:0] VERTEX_MAX   = 3'd5;

   // pentagon maps
   localparam int MAP_LOW_W  = 64;
   localparam int MAP_HIGH_W = 58;
   localparam logic [MAP_LOW_W-1:0]  MAP_LOW_RESET  = 64'd9512165637854609424;
   localparam logic [MAP_HIGH_W-1:0] MAP_HIGH_RESET = 58'd9016003938222336;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = MAP_LOW_W;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_LOW  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HIGH = 1'b1;

   // parameter defaults
   localparam int BASE_CELL_LIMIT_DEF = 122;
   localparam int DIGIT_LIMIT_DEF     = 15;

   // after decode: per-digit flags, only set for digits within the resolution
   typedef struct packed {
      logic                    top_bad;
      logic [MODE_W-1:0]       mode;
      logic [AUX_W-1:0]        aux;
      logic                    base_ok;
      logic                    pent_base;
      logic [MAX_DIGITS-1:0]   seven;
      logic [MAX_DIGITS-1:0]   nonzero;
      logic [MAX_DIGITS-1:0]   one;
   } decode_type;

   // after scan: digit flags reduced
   typedef struct packed {
      logic                    top_bad;
      logic [MODE_W-1:0]       mode;
      logic [AUX_W-1:0]        aux;
      logic                    base_ok;
      logic                    pent_base;
      logic                    has_seven;
      logic                    lead_one;
      logic                    lead_zero;
   } scan_type;

endpackage

// ===== hw/rtl/hcv_req_if.sv =====
// hcv_req_if: request channel carrying one raw grid index per transfer
// depends on hcv_pkg for the index width

interface hcv_req_if;
   import hcv_pkg::*;

   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] cell_index;

   modport source (output valid, output cell_index, input ready);
   modport sink   (input valid, input cell_index, output ready);
endinterface

// ===== hw/rtl/hcv_rsp_if.sv =====
// hcv_rsp_if: response channel carrying the validity and pentagon flags
// no dependencies

interface hcv_rsp_if;
   logic valid;
   logic ready;
   logic index_ok;
   logic pentagon_flag;

   modport source (output valid, output index_ok, output pentagon_flag, input ready);
   modport sink   (input valid, input index_ok, input pentagon_flag, output ready);
endinterface

// ===== hw/rtl/hex_cell_index_validator.sv =====
// hex_cell_index_validator: top level, three-stage pipeline decode -> scan -> judge
// a request passes the decode, scan and judge stage registers in that order
// throughput: one index per cycle while no stage is held; each stage register loads when empty or when
// the stage below moves, so back-pressure holds items in place
// reset: synchronous, clears all stage valid bits and reloads both pentagon maps
// depends on hcv_pkg, hcv_req_if, hcv_rsp_if, hcv_decode, hcv_scan, hcv_judge

module hex_cell_index_validator #(
   parameter int BASE_CELL_LIMIT = hcv_pkg::BASE_CELL_LIMIT_DEF,
   parameter int DIGIT_LIMIT     = hcv_pkg::DIGIT_LIMIT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   hcv_req_if.sink                            req_bus,
   hcv_rsp_if.source                          rsp_bus,
   input  logic                               csr_we,
   input  logic [hcv_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hcv_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import hcv_pkg::*;

   logic [MAP_LOW_W-1:0]  map_low_ff;
   logic [MAP_HIGH_W-1:0] map_high_ff;

   logic       s1_valid;
   logic       s1_ready;
   decode_type s1_data;
   logic       s2_valid;
   logic       s2_ready;
   scan_type   s2_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_low_ff  <= MAP_LOW_RESET;
         map_high_ff <= MAP_HIGH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAP_LOW:  map_low_ff  <= csr_wdata;
            CSR_MAP_HIGH: map_high_ff <= csr_wdata[MAP_HIGH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   hcv_decode #(
      .BASE_CELL_LIMIT (BASE_CELL_LIMIT),
      .DIGIT_LIMIT     (DIGIT_LIMIT)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_bus.valid),
      .cell_index (req_bus.cell_index),
      .in_ready   (req_bus.ready),
      .map_low    (map_low_ff),
      .map_high   (map_high_ff),
      .out_valid  (s1_valid),
      .out_data   (s1_data),
      .out_ready  (s1_ready)
   );

   hcv_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_data   (s1_data),
      .in_ready  (s1_ready),
      .out_valid (s2_valid),
      .out_data  (s2_data),
      .out_ready (s2_ready)
   );

   hcv_judge u_judge (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s2_valid),
      .in_data       (s2_data),
      .in_ready      (s2_ready),
      .out_valid     (rsp_bus.valid),
      .index_ok      (rsp_bus.index_ok),
      .pentagon_flag (rsp_bus.pentagon_flag),
      .out_ready     (rsp_bus.ready)
   );

   // request side only stalls when every stage is full and the response is held
   a_full_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (s1_valid && s2_valid && rsp_bus.valid && !rsp_bus.ready))
      else $error("request stalled with a free pipeline slot");

   // a stalled middle stage keeps its item
   a_scan_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_valid && !s2_ready) |=> s2_valid)
      else $error("scan stage item lost under stall");

   // an open first stage with no request empties
   a_decode_bubble: assert property (@(posedge clock) disable iff (reset)
      (req_bus.ready && !req_bus.valid) |=> !s1_valid)
      else $error("decode stage valid without a request transfer");

endmodule

// ===== hw/rtl/hcv_decode.sv =====
// hcv_decode: first pipeline stage, splits the index into fields, flags each digit
// and looks the base cell up in the pentagon maps; depends on hcv_pkg

module hcv_decode #(
   parameter int BASE_CELL_LIMIT = hcv_pkg::BASE_CELL_LIMIT_DEF,
   parameter int DIGIT_LIMIT     = hcv_pkg::DIGIT_LIMIT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [hcv_pkg::INDEX_W-1:0]       cell_index,
   output logic                              in_ready,
   input  logic [hcv_pkg::MAP_LOW_W-1:0]     map_low,
   input  logic [hcv_pkg::MAP_HIGH_W-1:0]    map_high,
   output logic                              out_valid,
   output hcv_pkg::decode_type               out_data,
   input  logic                              out_ready
);
   import hcv_pkg::*;

   logic                  valid_ff;
   decode_type            data_ff;
   decode_type            data_in;
   logic [RES_W-1:0]      res;
   logic [BASE_W-1:0]     base;
   logic [MAP_LOW_W-1:0]  map_high_ext;
   logic                  map_bit;
   logic [DIGIT_W-1:0]    digit;
   logic                  in_res;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   assign res          = cell_index[RES_POS +: RES_W];
   assign base         = cell_index[BASE_POS +: BASE_W];
   assign map_high_ext = {{(MAP_LOW_W-MAP_HIGH_W){1'b0}}, map_high};

   always_comb begin
      map_bit = base[BASE_W-1] ? map_high_ext[base[BASE_W-2:0]] : map_low[base[BASE_W-2:0]];
      data_in.top_bad   = cell_index[TOP_POS];
      data_in.mode      = cell_index[MODE_LSB +: MODE_W];
      data_in.aux       = cell_index[AUX_POS +: AUX_W];
      data_in.base_ok   = {1'b0, base} < 8'(BASE_CELL_LIMIT);
      data_in.pent_base = data_in.base_ok && map_bit;
      digit  = '0;
      in_res = 1'b0;
      // digit 0 sits just below the base cell field
      for (int i = 0; i < MAX_DIGITS; i++) begin
         digit  = cell_index[BASE_POS - DIGIT_W*i - 1 -: DIGIT_W];
         in_res = (i < DIGIT_LIMIT) && (5'(i) < {1'b0, res});
         data_in.seven[i]   = in_res && (digit == DIGIT_SEVEN);
         data_in.nonzero[i] = in_res && (digit != '0);
         data_in.one[i]     = in_res && (digit == DIGIT_ONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== hw/rtl/hcv_scan.sv =====
// hcv_scan: second pipeline stage, reduces the digit flags to a seven flag, an all-zero
// flag and the class of the leading non-zero digit; depends on hcv_pkg

module hcv_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  hcv_pkg::decode_type  in_data,
   output logic                 in_ready,
   output logic                 out_valid,
   output hcv_pkg::scan_type    out_data,
   input  logic                 out_ready
);
   import hcv_pkg::*;

   logic                  valid_ff;
   scan_type              data_ff;
   scan_type              data_in;
   logic [MAX_DIGITS-1:0] first_nz;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      // first_nz marks the leading non-zero digit, each bit on its own prefix mask
      for (int i = 0; i < MAX_DIGITS; i++) begin
         first_nz[i] = in_data.nonzero[i] &&
                       ((in_data.nonzero & ((MAX_DIGITS'(1) << i) - MAX_DIGITS'(1))) == '0);
      end
      data_in.top_bad   = in_data.top_bad;
      data_in.mode      = in_data.mode;
      data_in.aux       = in_data.aux;
      data_in.base_ok   = in_data.base_ok;
      data_in.pent_base = in_data.pent_base;
      data_in.has_seven = |in_data.seven;
      data_in.lead_one  = |(first_nz & in_data.one);
      data_in.lead_zero = !(|in_data.nonzero);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== hw/rtl/hcv_judge.sv =====
// hcv_judge: last pipeline stage, applies the per-mode rules and holds the
// response register; depends on hcv_pkg

module hcv_judge (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  hcv_pkg::scan_type in_data,
   output logic              in_ready,
   output logic              out_valid,
   output logic              index_ok,
   output logic              pentagon_flag,
   input  logic              out_ready
);
   import hcv_pkg::*;

   logic valid_ff;
   logic ok_ff;
   logic ok_in;
   logic pent_ff;
   logic pent_in;
   logic common_ok;

   assign in_ready      = !valid_ff || out_ready;
   assign out_valid     = valid_ff;
   assign index_ok      = ok_ff;
   assign pentagon_flag = pent_ff;

   always_comb begin
      common_ok = !in_data.top_bad && in_data.base_ok && !in_data.has_seven;
      case (in_data.mode)
         MODE_CELL: begin
            // k-axis rule on pentagon base cells
            ok_in = common_ok && !(in_data.pent_base && in_data.lead_one);
         end
         MODE_EDGE: begin
            ok_in = common_ok && (in_data.aux inside {[EDGE_DIR_MIN:EDGE_DIR_MAX]});
         end
         MODE_VERTEX: begin
            ok_in = common_ok && (in_data.aux <= VERTEX_MAX);
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
      pent_in = in_data.pent_base && in_data.lead_zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         ok_ff   <= ok_in;
         pent_ff <= pent_in;
      end
   end

endmodule
